// ===== hw/rtl/shash_pkg.sv =====
package shash_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned BLOCK_BITS = 512;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  typedef struct packed {
    logic       mode;
    logic [7:0] msg_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [BLOCK_BITS-1:0] blk;
    logic                  fin;
  } job_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                     input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== hw/rtl/shash_front.sv =====
module shash_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  shash_pkg::in_item_t in_data,
  input  logic                q_full,
  output logic                q_push,
  output shash_pkg::job_t     q_wdata
);
  import shash_pkg::*;

  typedef enum logic [2:0] {
    F_ACCEPT = 3'b001,
    F_ZERO   = 3'b010,
    F_LEN    = 3'b100
  } front_state_t;

  front_state_t          state;
  logic [5:0]            fill;
  logic [63:0]           total;
  logic [63:0]           lenr;
  logic [BLOCK_BITS-1:0] blk;

  logic       can_shift;
  logic       acc;
  logic       shift_en;
  logic [7:0] shift_byte;
  logic       fin_blk;

  assign can_shift = (fill != LAST_FILL) || !q_full;
  assign in_stall  = !((state == F_ACCEPT) && can_shift);
  assign acc       = in_valid && !in_stall;

  always_comb begin
    shift_en   = 1'b0;
    shift_byte = '0;
    fin_blk    = 1'b0;
    case (state)
      F_ACCEPT: begin
        if (acc) begin
          shift_en   = 1'b1;
          shift_byte = in_data.mode ? PAD_BYTE : in_data.msg_byte;
        end
      end
      F_ZERO: begin
        if (fill != LEN_FILL && can_shift) begin
          shift_en = 1'b1;
        end
      end
      F_LEN: begin
        if (can_shift) begin
          shift_en   = 1'b1;
          shift_byte = lenr[63:56];
          fin_blk    = (fill == LAST_FILL);
        end
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  assign q_push        = shift_en && (fill == LAST_FILL);
  assign q_wdata.blk   = {blk[BLOCK_BITS-9:0], shift_byte};
  assign q_wdata.fin   = fin_blk;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      blk <= {blk[BLOCK_BITS-9:0], shift_byte};
    end
    if (rst) begin
      state <= F_ACCEPT;
      fill  <= '0;
      total <= '0;
    end else begin
      if (shift_en) begin
        fill <= fill + 6'd1;
      end
      case (state)
        F_ACCEPT: begin
          if (acc && in_data.mode) begin
            lenr  <= {total[60:0], 3'b000};
            total <= '0;
            state <= F_ZERO;
          end else if (acc) begin
            total <= total + 64'd1;
          end
        end
        F_ZERO: begin
          if (fill == LEN_FILL) begin
            state <= F_LEN;
          end
        end
        F_LEN: begin
          if (shift_en) begin
            lenr <= {lenr[55:0], 8'h00};
            if (fill == LAST_FILL) begin
              state <= F_ACCEPT;
            end
          end
        end
        default: begin
          state <= F_ACCEPT;
        end
      endcase
    end
  end

  a_finish_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.mode) |=> in_stall)
    else $error("input taken during padding");

  a_push_only_full_block: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_wdata.fin) |-> (state == F_LEN))
    else $error("final block pushed outside length phase");

endmodule

// ===== hw/rtl/shash_fifo.sv =====
module shash_fifo #(
  parameter int unsigned DEPTH = shash_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  shash_pkg::job_t wdata,
  output logic            full,
  input  logic            pop,
  output shash_pkg::job_t rdata,
  output logic            empty
);
  import shash_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> !full)
    else $error("push into full queue");

endmodule

// ===== hw/rtl/shash_back.sv =====
module shash_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  shash_pkg::job_t      q_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output shash_pkg::out_item_t out_data
);
  import shash_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RUN  = 4'b0010,
    B_ADD  = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t state;
  logic [31:0] chain [8];
  logic [31:0] v     [8];
  logic [31:0] w     [16];
  logic [5:0]  rnd;
  logic [2:0]  idx;
  logic        fin;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic        out_free;

  assign t1 = v[7] + bsig1(v[4]) + ch(v[4], v[5], v[6]) + K_TABLE[rnd] + w[0];
  assign t2 = bsig0(v[0]) + maj(v[0], v[1], v[2]);
  assign w_new = w[0] + ssig0(w[1]) + w[9] + ssig1(w[14]);
  assign out_free = !out_valid || !out_stall;
  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          for (int i = 0; i < 16; i++) begin
            w[i] <= q_rdata.blk[BLOCK_BITS-1-32*i -: 32];
          end
          for (int i = 0; i < 8; i++) begin
            v[i] <= chain[i];
          end
          fin <= q_rdata.fin;
          rnd <= '0;
        end
      end
      B_RUN: begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= w_new;
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
        rnd  <= rnd + 6'd1;
      end
      B_ADD: begin
        idx <= '0;
      end
      B_EMIT: begin
        if (out_free) begin
          out_data.digest_word <= chain[idx];
          out_data.word_index  <= idx;
          out_data.last_word   <= (idx == LAST_WORD_IDX);
          idx <= idx + 3'd1;
        end
      end
      default: begin
        rnd <= rnd;
      end
    endcase

    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= INIT_H[i];
      end
    end else begin
      if (state == B_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (rnd == LAST_ROUND) begin
            state <= B_ADD;
          end
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= fin ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (out_free && idx == LAST_WORD_IDX) begin
            for (int i = 0; i < 8; i++) begin
              chain[i] <= INIT_H[i];
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_digest_words_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_word) |=> out_valid)
    else $error("gap inside digest");

  a_pop_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_RUN && rnd == 6'd0))
    else $error("job not started");

endmodule

// ===== hw/rtl/sha256_stream_hasher_core.sv =====
// SHA-256 over a byte stream. Send mode 0 items with one message byte each and a mode 1 item to
// close the message; the block then returns the eight digest words, index 0 first, last_word on
// index 7, and starts over from the initial hash for the next message. Append bytes are taken one
// per cycle while the block queue (QUEUE_DEPTH entries of 64 bytes) has room. Each 64-byte block
// passes through the compression unit as one load, 64 rounds at one round per cycle and one add,
// and the unit takes no new block from the queue until it is done with the last. A finish item
// stalls the input while the padding and length bytes are shifted in at one byte per cycle as
// long as the queue has room; after the last compression the digest words leave at one word per
// cycle from the output register while the output is not stalled.
module sha256_stream_hasher_core #(
  parameter int unsigned QUEUE_DEPTH = shash_pkg::FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  shash_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output shash_pkg::out_item_t out_data
);
  import shash_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_wdata;
  logic q_empty;
  logic q_pop;
  job_t q_rdata;

  shash_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  shash_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  shash_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
